>>> src/lpht_pkg.sv
package lpht_pkg;

	localparam int LEN_W    = 7;
	localparam int SLOT_W   = 6;
	localparam int OP_W     = 2;
	localparam int KEY_IN_W = 32;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;
	localparam int MARK_W   = 2;

	localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OOB       = 3'd4;

	localparam logic [LEN_W-1:0] SLOTS_RESET = 7'd64;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_LOAD,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef struct packed {
		logic                load_item;
		ptr_op_t             ptr_op;
		logic                rd_en;
		logic                mark_we;
		logic                wr_below;
		logic [MARK_W-1:0]   mark_wdata;
		logic                kv_we;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic                res_hit;
		logic                res_slot;
		logic                out_load;
	} lpht_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]   in_op;
		logic              in_home_oob;
		logic [OP_W-1:0]   op;
		logic [MARK_W-1:0] mark;
		logic              key_match;
		logic              next_oob;
		logic              ptr_zero;
		logic              out_free;
	} lpht_stat_t;

endpackage

>>> src/lpht_if.sv
interface lpht_item_if;
	logic                            valid;
	logic                            ready;
	logic [lpht_pkg::OP_W-1:0]       operation;
	logic [lpht_pkg::SLOT_W-1:0]     home_slot;
	logic [lpht_pkg::KEY_IN_W-1:0]   key;
	logic [lpht_pkg::VAL_W-1:0]      value;

	modport source (output valid, operation, home_slot, key, value, input ready);
	modport sink (input valid, operation, home_slot, key, value, output ready);
endinterface

interface lpht_result_if;
	logic                            valid;
	logic                            ready;
	logic [lpht_pkg::STATUS_W-1:0]   status;
	logic [lpht_pkg::VAL_W-1:0]      found_value;
	logic [lpht_pkg::SLOT_W-1:0]     slot;

	modport source (output valid, status, found_value, slot, input ready);
	modport sink (input valid, status, found_value, slot, output ready);
endinterface

>>> src/lpht_dp.sv
module lpht_dp #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpht_pkg::LEN_W-1:0]        cfg_wdata,
	input  logic [lpht_pkg::OP_W-1:0]         operation,
	input  logic [lpht_pkg::SLOT_W-1:0]       home_slot,
	input  logic [lpht_pkg::KEY_IN_W-1:0]     key,
	input  logic [lpht_pkg::VAL_W-1:0]        value,
	input  lpht_pkg::lpht_cmd_t               cmd,
	output lpht_pkg::lpht_stat_t              stat,
	lpht_result_if.source                     result
);
	import lpht_pkg::*;

	// probing never reaches past the largest slot count the register can hold
	localparam int LEN_MAX     = (1 << LEN_W) - 1;
	localparam int STORE_DEPTH = (TABLE_DEPTH < LEN_MAX + 1) ? TABLE_DEPTH : LEN_MAX + 1;
	localparam int LEN_CAP     = (TABLE_DEPTH < LEN_MAX) ? TABLE_DEPTH : LEN_MAX;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [MARK_W-1:0]         mark_mem [STORE_DEPTH];
	logic [KEY_WIDTH-1:0]      key_mem  [STORE_DEPTH];
	logic [VAL_W-1:0]          val_mem  [STORE_DEPTH];
	logic [STORE_DEPTH-1:0]    mark_vld_q;

	logic [LEN_W-1:0]          slots_q;
	logic [LEN_W-1:0]          len;
	logic [OP_W-1:0]           op_q;
	logic [KEY_WIDTH-1:0]      key_q;
	logic [VAL_W-1:0]          val_q;
	logic [LEN_W-1:0]          ptr_q;
	logic [LEN_W-1:0]          ptr_d;
	logic [LEN_W:0]            ptr_inc;
	logic [LEN_W-1:0]          wr_ptr;
	logic [IDX_W-1:0]          rd_addr;
	logic [IDX_W-1:0]          wr_addr;
	logic [KEY_IN_W+KEY_WIDTH-1:0] key_ext;

	logic [MARK_W-1:0]         mark_rd_q;
	logic                      vld_rd_q;
	logic [KEY_WIDTH-1:0]      key_rd_q;
	logic [VAL_W-1:0]          val_rd_q;

	logic [STATUS_W-1:0]       res_status_q;
	logic [VAL_W-1:0]          res_value_q;
	logic [SLOT_W-1:0]         res_slot_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic [VAL_W-1:0]          out_value_q;
	logic [SLOT_W-1:0]         out_slot_q;

	assign key_ext = {{KEY_WIDTH{1'b0}}, key};
	assign len     = (slots_q < LEN_W'(LEN_CAP)) ? slots_q : LEN_W'(LEN_CAP);
	assign ptr_inc = {1'b0, ptr_q} + 1'b1;

	always_comb begin
		unique case (cmd.ptr_op)
			PTR_HOLD: ptr_d = ptr_q;
			PTR_LOAD: ptr_d = LEN_W'(home_slot);
			PTR_INC:  ptr_d = ptr_inc[LEN_W-1:0];
			PTR_DEC:  ptr_d = ptr_q - 1'b1;
			default:  ptr_d = ptr_q;
		endcase
	end

	assign wr_ptr  = cmd.wr_below ? (ptr_q - 1'b1) : ptr_q;
	assign rd_addr = ptr_d[IDX_W-1:0];
	assign wr_addr = wr_ptr[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_RESET;
		end else if (cfg_we) begin
			slots_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= operation;
			key_q <= key_ext[KEY_WIDTH-1:0];
			val_q <= value;
		end
		if (cmd.ptr_op != PTR_HOLD) begin
			ptr_q <= ptr_d;
		end
	end

	// slot stores: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mark_we) begin
			mark_mem[wr_addr] <= cmd.mark_wdata;
		end
		if (cmd.kv_we) begin
			key_mem[wr_addr] <= key_q;
			val_mem[wr_addr] <= val_q;
		end
		if (cmd.rd_en) begin
			mark_rd_q <= mark_mem[rd_addr];
			key_rd_q  <= key_mem[rd_addr];
			val_rd_q  <= val_mem[rd_addr];
		end
	end

	// a slot never written since reset reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_vld_q <= '0;
			vld_rd_q   <= 1'b0;
		end else begin
			if (cmd.mark_we) begin
				mark_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				vld_rd_q <= mark_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_hit ? val_rd_q : '0;
			res_slot_q   <= cmd.res_slot ? ptr_q[SLOT_W-1:0] : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_slot_q   <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = out_status_q;
	assign result.found_value = out_value_q;
	assign result.slot        = out_slot_q;

	assign stat.in_op       = operation;
	assign stat.in_home_oob = (LEN_W'(home_slot) >= len);
	assign stat.op          = op_q;
	assign stat.mark        = vld_rd_q ? mark_rd_q : MARK_EMPTY;
	assign stat.key_match   = (key_rd_q == key_q);
	assign stat.next_oob    = (ptr_inc >= {1'b0, len});
	assign stat.ptr_zero    = (ptr_q == '0);
	assign stat.out_free    = !out_valid_q || result.ready;

	a_below_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_we && cmd.wr_below |-> ptr_q != '0)
		else $error("write below slot zero");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || result.ready))
		else $error("result overwritten before transfer");

endmodule

>>> src/lpht_ctrl.sv
module lpht_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  lpht_pkg::lpht_stat_t  stat,
	output lpht_pkg::lpht_cmd_t   cmd
);
	import lpht_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_NEXT,
		S_DOWN,
		S_SWEEP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   op_valid;

	assign item_ready = (state_q == S_IDLE);
	assign op_valid   = (stat.in_op == OP_STORE) || (stat.in_op == OP_FIND) ||
		(stat.in_op == OP_REMOVE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					cmd.ptr_op    = PTR_LOAD;
					priority if (!op_valid) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_NOT_FOUND;
						state_d        = S_FIN;
					end else if (stat.in_home_oob) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_OOB;
						state_d        = S_FIN;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				priority if (stat.mark == MARK_EMPTY) begin
					cmd.res_load = 1'b1;
					if (stat.op == OP_STORE) begin
						cmd.mark_we    = 1'b1;
						cmd.mark_wdata = MARK_USED;
						cmd.kv_we      = 1'b1;
						cmd.res_status = ST_STORED;
						cmd.res_slot   = 1'b1;
					end else begin
						cmd.res_status = ST_NOT_FOUND;
					end
					state_d = S_FIN;
				end else if (stat.mark == MARK_USED && stat.key_match) begin
					cmd.res_load = 1'b1;
					cmd.res_slot = 1'b1;
					priority if (stat.op == OP_STORE) begin
						cmd.res_status = ST_DUPLICATE;
						state_d        = S_FIN;
					end else if (stat.op == OP_FIND) begin
						cmd.res_status = ST_FOUND;
						cmd.res_hit    = 1'b1;
						state_d        = S_FIN;
					end else begin
						cmd.res_status = ST_FOUND;
						cmd.res_hit    = 1'b1;
						// past the end counts as empty: clear and sweep down
						if (stat.next_oob) begin
							cmd.mark_we    = 1'b1;
							cmd.mark_wdata = MARK_EMPTY;
							state_d        = S_DOWN;
						end else begin
							cmd.ptr_op = PTR_INC;
							cmd.rd_en  = 1'b1;
							state_d    = S_NEXT;
						end
					end
				end else if (stat.next_oob) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_OOB;
					state_d        = S_FIN;
				end else begin
					cmd.ptr_op = PTR_INC;
					cmd.rd_en  = 1'b1;
				end
			end
			S_NEXT: begin
				// pointer sits on the slot after the match
				cmd.mark_we  = 1'b1;
				cmd.wr_below = 1'b1;
				if (stat.mark != MARK_EMPTY) begin
					cmd.mark_wdata = MARK_TOMB;
					state_d        = S_FIN;
				end else begin
					cmd.mark_wdata = MARK_EMPTY;
					cmd.ptr_op     = PTR_DEC;
					state_d        = S_DOWN;
				end
			end
			S_DOWN: begin
				if (stat.ptr_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.ptr_op = PTR_DEC;
					cmd.rd_en  = 1'b1;
					state_d    = S_SWEEP;
				end
			end
			S_SWEEP: begin
				if (stat.mark == MARK_TOMB) begin
					cmd.mark_we    = 1'b1;
					cmd.mark_wdata = MARK_EMPTY;
					state_d        = S_DOWN;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_read_before_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK || state_q == S_NEXT || state_q == S_SWEEP) |-> $past(cmd.rd_en))
		else $error("slot data used without a read");

	a_store_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.kv_we |-> (stat.op == OP_STORE && stat.mark == MARK_EMPTY))
		else $error("entry written outside a store into an empty slot");

	a_probe_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.ptr_op == PTR_INC) |-> !stat.next_oob)
		else $error("probe past the active slots");

endmodule

>>> src/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing and no wraparound. Each transfer on item
// is a store, find or remove with a precomputed home slot; each gives exactly one transfer
// on result. Items are handled one at a time: an item is taken, then probes one slot per
// cycle through the single registered read port of the slot memories, and its result is
// staged in the res and out registers before it is offered on result.
// A remove that matches reads the next slot, unless the match sits in the last active
// slot; when the entry is cleared it then sweeps down through the tombstones below,
// clearing each, until a slot that is not a tombstone or slot 0. A new item is taken while
// the previous result still waits on result. slots_in_use is written through cfg_we/cfg_wdata
// and resets to 64; it is to be written only while the table is idle, which the block
// itself does not enforce. Slot marks are qualified by per-slot valid flops, so the table
// is empty right after reset with no clearing pass.
module linear_probe_hash_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lpht_pkg::LEN_W-1:0]   cfg_wdata,
	lpht_item_if.sink                    item,
	lpht_result_if.source                result
);
	import lpht_pkg::*;

	lpht_cmd_t  cmd;
	lpht_stat_t stat;
	logic       item_ready;

	assign item.ready = item_ready;

	lpht_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	lpht_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.operation (item.operation),
		.home_slot (item.home_slot),
		.key       (item.key),
		.value     (item.value),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule
